// File: rtl/fsip_pkg.sv
package fsip_pkg;

  // kinds of work handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,  // one character, final
    CMD_PAIR = 2'd1,  // percent sign, then the stored character
    CMD_DEC  = 2'd2,  // signed decimal conversion of the argument
    CMD_HEX  = 2'd3   // unsigned uppercase hex conversion of the argument
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  ch;
    logic [31:0] arg;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_TAIL = 4'b0010,
    BK_CONV = 4'b0100,
    BK_EMIT = 4'b1000
  } back_state_e;

  // character codes
  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharMinus   = 8'h2d;
  localparam logic [7:0] CharLowC    = 8'h63;
  localparam logic [7:0] CharLowD    = 8'h64;
  localparam logic [7:0] CharLowP    = 8'h70;
  localparam logic [7:0] CharLowX    = 8'h78;

  // digit characters, 0-9 then A-F
  localparam logic [7:0] HexChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // digit stack: a 32-bit value has at most ten decimal digits
  localparam int unsigned DigitDepth = 10;
  localparam int unsigned DigitIdxW  = 4;

  // divide by ten: q = (x * RecipTen) >> RecipShift, exact for 32-bit x
  localparam logic [31:0] RecipTen   = 32'hcccc_cccd;
  localparam int unsigned RecipShift = 35;

endpackage

// File: rtl/fsip_front.sv
module fsip_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          fmt_char_i,
  input  logic [31:0]         arg_word_i,
  output logic                cmd_push_o,
  output fsip_pkg::cmd_t      cmd_o,
  input  logic                cmd_full_i
);

  logic accept;
  logic pending_q, pending_d;
  logic has_cmd;

  assign full   = cmd_full_i;
  assign accept = push & ~cmd_full_i;

  // classify the format byte against the pending percent flag
  always_comb begin
    pending_d   = pending_q;
    has_cmd     = 1'b0;
    cmd_o.kind  = fsip_pkg::CMD_CHAR;
    cmd_o.ch    = fmt_char_i;
    cmd_o.arg   = arg_word_i;
    if (fmt_char_i == fsip_pkg::CharNul) begin
      pending_d = 1'b0;
    end else if (!pending_q) begin
      if (fmt_char_i == fsip_pkg::CharPercent) begin
        pending_d = 1'b1;
      end else begin
        has_cmd = 1'b1;
      end
    end else begin
      pending_d = 1'b0;
      has_cmd   = 1'b1;
      case (fmt_char_i)
        fsip_pkg::CharLowD: begin
          cmd_o.kind = fsip_pkg::CMD_DEC;
        end
        fsip_pkg::CharLowX, fsip_pkg::CharLowP: begin
          cmd_o.kind = fsip_pkg::CMD_HEX;
        end
        fsip_pkg::CharLowC: begin
          cmd_o.ch = arg_word_i[7:0];
        end
        fsip_pkg::CharPercent: begin
          cmd_o.ch = fsip_pkg::CharPercent;
        end
        default: begin
          cmd_o.kind = fsip_pkg::CMD_PAIR;
        end
      endcase
    end
  end

  assign cmd_push_o = accept & has_cmd;

  // percent flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (accept) begin
      pending_q <= pending_d;
    end
  end

endmodule

// File: rtl/fsip_cmd_queue.sv
module fsip_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fsip_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output fsip_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  fsip_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/fsip_back.sv
module fsip_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  fsip_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_char_o,
  output logic           last_o
);

  fsip_pkg::back_state_e state_q, state_d;

  logic [31:0] mag_q, mag_d;
  logic        dec_q, dec_d;
  logic [7:0]  ch_q, ch_d;
  logic [fsip_pkg::DigitIdxW-1:0] dcnt_q, dcnt_d;
  logic [3:0]  stack_q [fsip_pkg::DigitDepth];
  logic        stack_we;
  logic [fsip_pkg::DigitIdxW-1:0] rd_idx;

  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem_full;
  logic [3:0]  digit;
  logic [31:0] mag_next;
  logic [31:0] mag_abs;

  logic        ob_push, ob_last;
  logic [7:0]  ob_char;
  logic [7:0]  ob_char_q [2];
  logic        ob_last_q [2];
  logic        ob_wr_q, ob_rd_q;
  logic [1:0]  ob_cnt_q;
  logic        space;
  logic        ob_pop;

  // one digit per cycle: divide by ten through the reciprocal, or shift a nibble
  assign prod     = 64'(mag_q) * 64'(fsip_pkg::RecipTen);
  assign quo      = {3'b000, prod[63:fsip_pkg::RecipShift]};
  assign rem_full = mag_q - ((quo << 3) + (quo << 1));
  assign digit    = dec_q ? rem_full[3:0] : mag_q[3:0];
  assign mag_next = dec_q ? quo : {4'h0, mag_q[31:4]};
  assign mag_abs  = cmd_i.arg[31] ? (32'd0 - cmd_i.arg) : cmd_i.arg;
  assign rd_idx   = dcnt_q - {{(fsip_pkg::DigitIdxW-1){1'b0}}, 1'b1};

  assign space = (ob_cnt_q != 2'd2);

  // sequencer
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    dec_d     = dec_q;
    ch_d      = ch_q;
    dcnt_d    = dcnt_q;
    stack_we  = 1'b0;
    cmd_pop_o = 1'b0;
    ob_push   = 1'b0;
    ob_char   = cmd_i.ch;
    ob_last   = 1'b1;
    case (state_q)
      fsip_pkg::BK_IDLE: begin
        if (!cmd_empty_i && space) begin
          cmd_pop_o = 1'b1;
          dcnt_d    = '0;
          case (cmd_i.kind)
            fsip_pkg::CMD_CHAR: begin
              ob_push = 1'b1;
            end
            fsip_pkg::CMD_PAIR: begin
              ob_push = 1'b1;
              ob_char = fsip_pkg::CharPercent;
              ob_last = 1'b0;
              ch_d    = cmd_i.ch;
              state_d = fsip_pkg::BK_TAIL;
            end
            fsip_pkg::CMD_DEC: begin
              dec_d   = 1'b1;
              mag_d   = mag_abs;
              ob_push = cmd_i.arg[31];
              ob_char = fsip_pkg::CharMinus;
              ob_last = 1'b0;
              state_d = fsip_pkg::BK_CONV;
            end
            fsip_pkg::CMD_HEX: begin
              dec_d   = 1'b0;
              mag_d   = cmd_i.arg;
              state_d = fsip_pkg::BK_CONV;
            end
            default: begin
              state_d = fsip_pkg::BK_IDLE;
            end
          endcase
        end
      end
      fsip_pkg::BK_TAIL: begin
        if (space) begin
          ob_push = 1'b1;
          ob_char = ch_q;
          state_d = fsip_pkg::BK_IDLE;
        end
      end
      fsip_pkg::BK_CONV: begin
        stack_we = 1'b1;
        dcnt_d   = dcnt_q + {{(fsip_pkg::DigitIdxW-1){1'b0}}, 1'b1};
        mag_d    = mag_next;
        if (mag_next == 32'd0) begin
          state_d = fsip_pkg::BK_EMIT;
        end
      end
      fsip_pkg::BK_EMIT: begin
        if (space) begin
          ob_push = 1'b1;
          ob_char = fsip_pkg::HexChars[stack_q[rd_idx]];
          ob_last = (rd_idx == '0);
          dcnt_d  = rd_idx;
          if (rd_idx == '0) begin
            state_d = fsip_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_d = fsip_pkg::BK_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsip_pkg::BK_IDLE;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // conversion payload
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    dec_q <= dec_d;
    ch_q  <= ch_d;
  end

  // digit stack, least significant digit at the bottom
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_q[dcnt_q] <= digit;
    end
  end

  // two-word output buffer
  assign empty      = (ob_cnt_q == 2'd0);
  assign ob_pop     = pop & ~empty;
  assign out_char_o = ob_char_q[ob_rd_q];
  assign last_o     = ob_last_q[ob_rd_q];

  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      ob_char_q[ob_wr_q] <= ob_char;
      ob_last_q[ob_wr_q] <= ob_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      if (ob_push) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (ob_pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
      ob_cnt_q <= ob_cnt_q + {1'b0, ob_push} - {1'b0, ob_pop};
    end
  end

  // checks
  a_no_ob_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_push |-> (ob_cnt_q != 2'd2))
    else $error("output buffer written while full");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fsip_pkg::BK_CONV) |-> (dcnt_q < fsip_pkg::DigitIdxW'(fsip_pkg::DigitDepth)))
    else $error("digit stack overrun");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fsip_pkg::BK_EMIT) |-> (dcnt_q != '0))
    else $error("emitting from an empty digit stack");

  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (!cmd_empty_i && state_q == fsip_pkg::BK_IDLE))
    else $error("command taken while none waits or while busy");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_push && ob_last) |=> (state_q == fsip_pkg::BK_IDLE))
    else $error("final word written while the item still runs");

endmodule

// File: rtl/format_string_integer_printer.sv
// an echoed word passes the command queue, then the output buffer, to the ports
// an unknown sequence gives a percent sign and then the stored character; a number
//   has a start step, then its digits from the shared divide-by-ten / nibble unit,
//   then one output word per cycle while the output buffer has space
// a 2-entry command queue lets the front end take items while the back end runs
// reset: asynchronous, active low; clears the percent flag and empties all queues
module format_string_integer_printer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] arg_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  fsip_pkg::cmd_t cmd_in;
  fsip_pkg::cmd_t cmd_out;

  // classify format bytes
  fsip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .fmt_char_i (fmt_char_i),
    .arg_word_i (arg_word_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // decouple front and back
  fsip_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_out),
    .empty_o (cmd_empty)
  );

  // convert and emit characters
  fsip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule
